>>> rtl/mde_pkg.sv
// Package for the depth-first maze exploration step.
// Holds side mark codes, move codes, the shared side unit's request types and
// the helpers that pick or replace one side in a packed cell word.
package mde_pkg;

	localparam int MARKS_W = 12;
	localparam int STAGE_W = 2;
	localparam int WORD_W  = MARKS_W + STAGE_W;

	typedef enum logic [2:0] {
		MK_UNKNOWN  = 3'd0,
		MK_WALL     = 3'd1,
		MK_WAY      = 3'd2,
		MK_EXPLORED = 3'd3,
		MK_ENTRY    = 3'd4
	} mark_t;

	localparam logic [1:0] SIDE_N = 2'd0;
	localparam logic [1:0] SIDE_E = 2'd1;
	localparam logic [1:0] SIDE_S = 2'd2;
	localparam logic [1:0] SIDE_W = 2'd3;

	localparam logic [STAGE_W-1:0] STG_NEW   = 2'd0;
	localparam logic [STAGE_W-1:0] STG_WALLS = 2'd1;
	localparam logic [STAGE_W-1:0] STG_DONE  = 2'd2;

	localparam logic [2:0] MV_FRONT = 3'd0;
	localparam logic [2:0] MV_RIGHT = 3'd1;
	localparam logic [2:0] MV_BACK  = 3'd2;
	localparam logic [2:0] MV_LEFT  = 3'd3;
	localparam logic [2:0] MV_STOP  = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RECORD,
		OP_TAKE,
		OP_ENTRY,
		OP_MATCH
	} alu_op_t;

	typedef struct packed {
		alu_op_t    op;
		logic [1:0] side;
		logic       arg;
	} alu_req_t;

	typedef struct packed {
		logic               hit;
		logic [MARKS_W-1:0] marks;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START_WR,
		ST_RD_C,
		ST_LD_C,
		ST_REC,
		ST_NB_RD,
		ST_NB_CHK,
		ST_ENTRY,
		ST_SCAN,
		ST_BACK,
		ST_DONE,
		ST_REPLY
	} st_t;

	function automatic mark_t get_mark(input logic [MARKS_W-1:0] m, input logic [1:0] s);
		return mark_t'(m[3*s +: 3]);
	endfunction

	function automatic logic [MARKS_W-1:0] set_mark(input logic [MARKS_W-1:0] m,
		input logic [1:0] s, input mark_t v);
		logic [MARKS_W-1:0] r;
		r = m;
		r[3*s +: 3] = v;
		return r;
	endfunction

endpackage

>>> rtl/mde_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mde_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/mde_side_alu.sv
// Shared side unit: reads one side mark of a cell word, compares it and
// rewrites it according to the requested operation. Depends on mde_pkg.
module mde_side_alu import mde_pkg::*; (
	input  logic [MARKS_W-1:0] marks,
	input  alu_req_t           req,
	output alu_rsp_t           rsp
);

	always_comb begin
		mark_t m;
		m = get_mark(marks, req.side);
		rsp.hit   = 1'b0;
		rsp.marks = marks;
		unique case (req.op)
			OP_RECORD: begin
				if (m == MK_UNKNOWN) begin
					rsp.marks = set_mark(marks, req.side, req.arg ? MK_WALL : MK_WAY);
				end
			end
			OP_TAKE: begin
				if (m == MK_WAY) begin
					rsp.hit   = 1'b1;
					rsp.marks = set_mark(marks, req.side, MK_EXPLORED);
				end
			end
			OP_ENTRY: begin
				if (m != MK_WALL) begin
					rsp.marks = set_mark(marks, req.side, MK_ENTRY);
				end
			end
			OP_MATCH: begin
				rsp.hit = (m == MK_ENTRY);
			end
			default: begin
				rsp.hit = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/maze_dfs_explore_step_top.sv
// Top level of the depth-first maze exploration step: sequencer, cell map RAM
// and the shared side unit. Depends on mde_pkg, mde_ram and mde_side_alu.
//
//  channel   ports                                            handshake
//  --------  -----------------------------------------------  ------------------
//  command   cmd cell_x cell_y heading wall_left/front/right  start & !busy
//  result    move                                             done, one cycle
//
// An arrival reads its cell; on a first visit it records the walls and reads up to four neighbors
// through the one map RAM read port, handling one side per cycle through the side unit. A cell
// whose walls are known goes straight to the scan of its sides, a fully explored cell to the back-out search.
// A start command sweeps all MAZE_SIZE*MAZE_SIZE words of the map, then writes the start wall
// when the cell is inside the map and answers stop; reset runs the same sweep with busy high. The
// receiver cannot stall: each word on move is valid only in the cycle that done is high.
module maze_dfs_explore_step_top import mde_pkg::*; #(
	parameter int MAZE_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       cmd,
	input  logic [3:0] cell_x,
	input  logic [3:0] cell_y,
	input  logic [1:0] heading,
	input  logic       wall_left,
	input  logic       wall_front,
	input  logic       wall_right,
	output logic       busy,
	output logic       done,
	output logic [2:0] move
);

	localparam int CELLS = MAZE_SIZE * MAZE_SIZE;
	localparam int AW    = $clog2(CELLS);

	st_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [1:0]         cnt_q;
	logic               start_q;
	logic               inside_q;
	logic [3:0]         x_q, y_q;
	logic [1:0]         h_q;
	logic               wl_q, wf_q, wr_q;
	logic [AW-1:0]      c_addr_q, nb_addr_q;
	logic [MARKS_W-1:0] cur_q;
	logic [STAGE_W-1:0] stage_q;
	logic [2:0]         move_q;

	logic               accept;
	logic               inside_in;
	logic [AW-1:0]      c_addr_in;
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [WORD_W-1:0]  wdata, rdata;
	logic [MARKS_W-1:0] alu_marks;
	alu_req_t           req;
	alu_rsp_t           rsp;
	logic               nb_ok;
	logic [AW-1:0]      nb_addr_d;
	logic [1:0]         nb_side;
	logic               rec_arg;

	assign accept    = start && (state_q == ST_IDLE);
	assign inside_in = (32'(cell_x) < MAZE_SIZE) && (32'(cell_y) < MAZE_SIZE);
	assign c_addr_in = AW'(32'(cell_x) * MAZE_SIZE + 32'(cell_y));

	// Neighbor walk: west, east, south, north
	always_comb begin
		unique case (cnt_q)
			2'd0: begin
				nb_ok     = (x_q != 4'd0);
				nb_addr_d = c_addr_q - AW'(MAZE_SIZE);
				nb_side   = SIDE_W;
			end
			2'd1: begin
				nb_ok     = (32'(x_q) < MAZE_SIZE - 1);
				nb_addr_d = c_addr_q + AW'(MAZE_SIZE);
				nb_side   = SIDE_E;
			end
			2'd2: begin
				nb_ok     = (y_q != 4'd0);
				nb_addr_d = c_addr_q - AW'(1);
				nb_side   = SIDE_S;
			end
			default: begin
				nb_ok     = (32'(y_q) < MAZE_SIZE - 1);
				nb_addr_d = c_addr_q + AW'(1);
				nb_side   = SIDE_N;
			end
		endcase
	end

	always_comb begin
		case (cnt_q)
			2'd0:    rec_arg = wl_q;
			2'd1:    rec_arg = wf_q;
			default: rec_arg = wr_q;
		endcase
	end

	mde_side_alu u_alu (
		.marks (alu_marks),
		.req   (req),
		.rsp   (rsp)
	);

	mde_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELLS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = c_addr_q;
		wdata     = '0;
		raddr     = c_addr_q;
		alu_marks = cur_q;
		req       = '{op: OP_NONE, side: 2'd0, arg: 1'b0};
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = start_q ? ST_START_WR : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (!cmd) begin
						state_d = ST_CLEAR;
					end else if (inside_in) begin
						state_d = ST_RD_C;
					end else begin
						state_d = ST_REPLY;
					end
				end
			end
			ST_START_WR: begin
				we      = inside_q;
				wdata   = {STG_NEW, set_mark('0, 2'(h_q + 2'd2), MK_WALL)};
				state_d = ST_IDLE;
			end
			ST_RD_C: begin
				state_d = ST_LD_C;
			end
			ST_LD_C: begin
				if (rdata[WORD_W-1 -: STAGE_W] == STG_NEW) begin
					state_d = ST_REC;
				end else if (rdata[WORD_W-1 -: STAGE_W] == STG_WALLS) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_BACK;
				end
			end
			ST_REC: begin
				req = '{op: OP_RECORD, side: 2'(h_q + cnt_q + 2'd3), arg: rec_arg};
				if (cnt_q == 2'd2) begin
					state_d = ST_NB_RD;
				end
			end
			ST_NB_RD: begin
				raddr = nb_addr_d;
				if (nb_ok) begin
					state_d = ST_NB_CHK;
				end else if (cnt_q == 2'd3) begin
					state_d = ST_ENTRY;
				end
			end
			ST_NB_CHK: begin
				alu_marks = rdata[MARKS_W-1:0];
				req       = '{op: OP_TAKE, side: 2'(nb_side + 2'd2), arg: 1'b0};
				we        = rsp.hit;
				waddr     = nb_addr_q;
				wdata     = {rdata[WORD_W-1 -: STAGE_W], rsp.marks};
				state_d   = (cnt_q == 2'd3) ? ST_ENTRY : ST_NB_RD;
			end
			ST_ENTRY: begin
				req     = '{op: OP_ENTRY, side: 2'(h_q + 2'd2), arg: 1'b0};
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				req = '{op: OP_TAKE, side: 2'(h_q + cnt_q), arg: 1'b0};
				if (rsp.hit) begin
					state_d = ST_DONE;
				end else if (cnt_q == 2'd3) begin
					state_d = ST_BACK;
				end
			end
			ST_BACK: begin
				req = '{op: OP_MATCH, side: cnt_q, arg: 1'b0};
				if (rsp.hit || cnt_q == 2'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				we      = 1'b1;
				wdata   = {stage_q, cur_q};
				state_d = ST_IDLE;
			end
			ST_REPLY: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			cnt_q   <= 2'd0;
			start_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == AW'(CELLS - 1)) ? '0 : clr_q + AW'(1);
			end
			if (accept) begin
				start_q <= !cmd;
				cnt_q   <= 2'd0;
			end
			unique case (state_q) inside
				ST_LD_C, ST_ENTRY: cnt_q <= 2'd0;
				ST_REC:            cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				ST_NB_RD: begin
					if (!nb_ok) begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_NB_CHK, ST_SCAN, ST_BACK: cnt_q <= cnt_q + 2'd1;
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			inside_q <= inside_in;
			x_q      <= cell_x;
			y_q      <= cell_y;
			h_q      <= heading;
			wl_q     <= wall_left;
			wf_q     <= wall_front;
			wr_q     <= wall_right;
			c_addr_q <= c_addr_in;
			move_q   <= MV_STOP;
		end
		unique case (state_q)
			ST_LD_C: begin
				cur_q   <= rdata[MARKS_W-1:0];
				stage_q <= rdata[WORD_W-1 -: STAGE_W];
			end
			ST_REC: cur_q <= rsp.marks;
			ST_NB_RD: nb_addr_q <= nb_addr_d;
			ST_NB_CHK: begin
				if (rsp.hit) begin
					cur_q <= set_mark(cur_q, nb_side, MK_EXPLORED);
				end
			end
			ST_ENTRY: begin
				cur_q   <= rsp.marks;
				stage_q <= STG_WALLS;
			end
			ST_SCAN: begin
				if (rsp.hit) begin
					cur_q  <= rsp.marks;
					move_q <= {1'b0, cnt_q};
				end else if (cnt_q == 2'd3) begin
					stage_q <= STG_DONE;
				end
			end
			ST_BACK: begin
				if (rsp.hit) begin
					move_q <= {1'b0, 2'(cnt_q - h_q)};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_START_WR) || (state_q == ST_DONE) || (state_q == ST_REPLY);
	assign move = move_q;

endmodule

>>> rtl/mde_checker.sv
// Port-level checker for the maze exploration step, bound to the top level.
// Depends on mde_pkg for the move codes.
module mde_checker import mde_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] move
);

	a_move_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (move == MV_FRONT || move == MV_RIGHT || move == MV_BACK ||
			move == MV_LEFT || move == MV_STOP))
		else $error("result word carries an undefined move code");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command word accepted but block did not go busy");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after delivering its result");

endmodule

bind maze_dfs_explore_step_top mde_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.move   (move)
);

>>> tb/testbench.sv
// Self-checking bench for maze_dfs_explore_step_top: walks random walled mazes
// through start/arrival commands and checks every move against a local predictor.
// Depends on mde_pkg and the RTL of maze_dfs_explore_step_top.
module testbench;
	import mde_pkg::*;

	localparam int GRID        = 16;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int ITEM_TARGET = 1700;
	localparam int TAIL_CYCLES = 40;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_ARRIVE = 1'b1;

	// Map predictor and store of expected moves.
	class move_scoreboard;
		localparam int SIZE = 16;
		mark_t      side_mark [SIZE*SIZE][4];
		logic [1:0] stage [SIZE*SIZE];
		logic [2:0] move_q [$];
		int         errors;

		function new();
			errors = 0;
			wipe_map();
		endfunction

		function void wipe_map();
			for (int c = 0; c < SIZE*SIZE; c++) begin
				stage[c] = STG_NEW;
				for (int s = 0; s < 4; s++)
					side_mark[c][s] = MK_UNKNOWN;
			end
		endfunction

		// Mark both sides explored when the neighbor's facing side is still open.
		function void link_cells(int here, int there, logic [1:0] s);
			logic [1:0] f;
			f = s + 2'd2;
			if (side_mark[there][f] == MK_WAY) begin
				side_mark[there][f] = MK_EXPLORED;
				side_mark[here][s]  = MK_EXPLORED;
			end
		endfunction

		function logic [2:0] note_word(logic c, logic [3:0] x, logic [3:0] y, logic [1:0] h,
			logic wl, logic wf, logic wr);
			int         idx;
			logic [1:0] sl, sr, sb, s, d;
			logic [2:0] mv;
			bit         found;
			idx = int'(x) * SIZE + int'(y);
			sl = h + 2'd3;
			sr = h + 2'd1;
			sb = h + 2'd2;
			mv = MV_STOP;
			found = 1'b0;
			if (c == CMD_START) begin
				wipe_map();
				side_mark[idx][sb] = MK_WALL;
			end else begin
				if (stage[idx] == STG_NEW) begin
					if (side_mark[idx][sl] == MK_UNKNOWN)
						side_mark[idx][sl] = wl ? MK_WALL : MK_WAY;
					if (side_mark[idx][h] == MK_UNKNOWN)
						side_mark[idx][h] = wf ? MK_WALL : MK_WAY;
					if (side_mark[idx][sr] == MK_UNKNOWN)
						side_mark[idx][sr] = wr ? MK_WALL : MK_WAY;
					if (x > 0)
						link_cells(idx, idx - SIZE, SIDE_W);
					if (x < SIZE - 1)
						link_cells(idx, idx + SIZE, SIDE_E);
					if (y > 0)
						link_cells(idx, idx - 1, SIDE_S);
					if (y < SIZE - 1)
						link_cells(idx, idx + 1, SIDE_N);
					if (side_mark[idx][sb] != MK_WALL)
						side_mark[idx][sb] = MK_ENTRY;
					stage[idx] = STG_WALLS;
				end
				if (stage[idx] == STG_WALLS) begin
					for (int n = 0; n < 4; n++) begin
						s = h + n[1:0];
						if (!found && side_mark[idx][s] == MK_WAY) begin
							side_mark[idx][s] = MK_EXPLORED;
							mv = {1'b0, n[1:0]};
							found = 1'b1;
						end
					end
					if (!found)
						stage[idx] = STG_DONE;
				end
				// Back out through the entry side, relative to the current heading.
				for (int n = 0; n < 4; n++) begin
					if (!found && side_mark[idx][n] == MK_ENTRY) begin
						d = n[1:0] - h;
						mv = {1'b0, d};
						found = 1'b1;
					end
				end
			end
			move_q.push_back(mv);
			return mv;
		endfunction

		function void check_word(logic [2:0] got);
			logic [2:0] want;
			if (move_q.size() == 0) begin
				$error("move: expected nothing, actual %0d", got);
				errors++;
			end else begin
				want = move_q.pop_front();
				if (got !== want) begin
					$error("move: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return move_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       cmd;
	logic [3:0] cell_x;
	logic [3:0] cell_y;
	logic [1:0] heading;
	logic       wall_left;
	logic       wall_front;
	logic       wall_right;
	logic       busy;
	logic       done;
	logic [2:0] move;

	move_scoreboard sb;
	int             sent;
	int             cycles;
	bit             burst;

	// Maze used by the walks: open passages inside a rectangular region.
	bit open_e [GRID][GRID];
	bit open_n [GRID][GRID];
	int rx0, ry0, rw, rh;

	maze_dfs_explore_step_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.heading   (heading),
		.wall_left (wall_left),
		.wall_front(wall_front),
		.wall_right(wall_right),
		.busy      (busy),
		.done      (done),
		.move      (move)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_word(move);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic bit passable(int x, int y, logic [1:0] d);
		int nx, ny;
		nx = x;
		ny = y;
		case (d)
			SIDE_N: ny++;
			SIDE_E: nx++;
			SIDE_S: ny--;
			default: nx--;
		endcase
		if (nx < rx0 || nx >= rx0 + rw || ny < ry0 || ny >= ry0 + rh)
			return 1'b0;
		case (d)
			SIDE_N: return open_n[x][y];
			SIDE_E: return open_e[x][y];
			SIDE_S: return open_n[x][y-1];
			default: return open_e[x-1][y];
		endcase
	endfunction

	task automatic send_word(input logic c, input logic [3:0] x, input logic [3:0] y,
		input logic [1:0] h, input logic wl, input logic wf, input logic wr,
		output logic [2:0] mv);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd        <= c;
		cell_x     <= x;
		cell_y     <= y;
		heading    <= h;
		wall_left  <= wl;
		wall_front <= wf;
		wall_right <= wr;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		mv = sb.note_word(c, x, y, h, wl, wf, wr);
		sent++;
	endtask

	task automatic arrive_at(input int x, input int y, input logic [1:0] h,
		output logic [2:0] mv);
		send_word(CMD_ARRIVE, 4'(x), 4'(y), h, !passable(x, y, h + 2'd3), !passable(x, y, h),
			!passable(x, y, h + 2'd1), mv);
	endtask

	// Drop start and hold until every expected move has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_walk();
		int         x, y, steps, cap;
		logic [1:0] h;
		logic [2:0] mv;
		rw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, GRID) : $urandom_range(1, 5);
		rh = ($urandom_range(0, 7) == 0) ? $urandom_range(1, GRID) : $urandom_range(1, 5);
		rx0 = $urandom_range(0, GRID - rw);
		ry0 = $urandom_range(0, GRID - rh);
		for (int i = 0; i < GRID; i++)
			for (int j = 0; j < GRID; j++) begin
				open_e[i][j] = ($urandom_range(0, 2) != 0);
				open_n[i][j] = ($urandom_range(0, 2) != 0);
			end
		x = rx0 + $urandom_range(0, rw - 1);
		y = ry0 + $urandom_range(0, rh - 1);
		h = 2'($urandom);
		send_word(CMD_START, 4'(x), 4'(y), h, 1'($urandom), 1'($urandom), 1'($urandom), mv);
		// Cut some walks short so the next start lands on a half-explored map.
		cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 4 * rw * rh + 8;
		arrive_at(x, y, h, mv);
		steps = 1;
		while (mv != MV_STOP && steps < cap) begin
			h = h + mv[1:0];
			if (!passable(x, y, h))
				break;
			case (h)
				SIDE_N: y++;
				SIDE_E: x++;
				SIDE_S: y--;
				default: x--;
			endcase
			arrive_at(x, y, h, mv);
			steps++;
		end
		if (mv == MV_STOP)
			repeat ($urandom_range(0, 2)) arrive_at(x, y, 2'($urandom), mv);
	endtask

	task automatic send_noise();
		logic [2:0] mv;
		repeat ($urandom_range(1, 12)) begin
			send_word(($urandom_range(0, 9) == 0) ? CMD_START : CMD_ARRIVE, 4'($urandom),
				4'($urandom), 2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), mv);
		end
	endtask

	initial begin
		logic [2:0] mv;
		sb = new();
		sent = 0;
		cycles = 0;
		burst = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_START;
		cell_x = '0;
		cell_y = '0;
		heading = '0;
		wall_left = 1'b0;
		wall_front = 1'b0;
		wall_right = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Arrival on the map left by reset: all sides open, then back through the entry.
		send_word(CMD_ARRIVE, 4'd5, 4'd5, SIDE_E, 1'b0, 1'b0, 1'b0, mv);
		send_word(CMD_ARRIVE, 4'd5, 4'd5, SIDE_E, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd5, 4'd5, SIDE_E, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd5, 4'd5, SIDE_E, 1'b0, 1'b1, 1'b0, mv);
		send_word(CMD_ARRIVE, 4'd5, 4'd5, SIDE_N, 1'b1, 1'b0, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd5, 4'd5, SIDE_W, 1'b0, 1'b0, 1'b1, mv);
		// Short corridor from the lower left corner, back turns and stop at the start.
		send_word(CMD_START, 4'd0, 4'd0, SIDE_N, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd0, 4'd0, SIDE_N, 1'b1, 1'b0, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd0, 4'd1, SIDE_N, 1'b1, 1'b1, 1'b0, mv);
		send_word(CMD_ARRIVE, 4'd1, 4'd1, SIDE_E, 1'b0, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd1, 4'd2, SIDE_N, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd1, 4'd1, SIDE_S, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd0, 4'd1, SIDE_W, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd0, 4'd0, SIDE_S, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd0, 4'd0, SIDE_E, 1'b0, 1'b0, 1'b0, mv);
		// Upper right corner, facing west.
		send_word(CMD_START, 4'd15, 4'd15, SIDE_W, 1'b0, 1'b0, 1'b0, mv);
		send_word(CMD_ARRIVE, 4'd15, 4'd15, SIDE_W, 1'b0, 1'b0, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd14, 4'd15, SIDE_W, 1'b1, 1'b0, 1'b0, mv);
		send_word(CMD_ARRIVE, 4'd15, 4'd15, SIDE_N, 1'b1, 1'b1, 1'b1, mv);
		send_word(CMD_ARRIVE, 4'd15, 4'd15, SIDE_S, 1'b1, 1'b1, 1'b1, mv);
		drain();

		while (sent < ITEM_TARGET) begin
			burst = ($urandom_range(0, 3) == 0);
			run_walk();
			if ($urandom_range(0, 3) == 0)
				send_noise();
			if ($urandom_range(0, 7) == 0)
				drain();
		end
		burst = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
